// ===== hw/rtl/axis_angle_rotation_matrix_unit_assert.svh =====
// assertion macros for the axis-angle rotation matrix unit
// used by the top level only, which supplies clk and rst
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AARM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AARM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AARM_ASSERT(lbl, prop, msg)
`define AARM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/aarm_pkg.sv =====
// shared types, constants and fixed-point helpers for the rotation matrix unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 31;
  localparam int CORDIC_STEPS   = 17;
  localparam int NORM_LAT       = 1 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int CORDIC_LAT     = 1 + CORDIC_STEPS + 1;
  localparam int ANGLE_DLY      = NORM_LAT - CORDIC_LAT;

  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
  localparam logic signed [16:0] PI_Q13       = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13  = 17'sd12868;

  localparam logic signed [19:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1
  };

  typedef struct packed {
    logic signed [15:0] angle;
    logic               angle_invalid;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] unit_axis_x;
    logic signed [15:0] unit_axis_y;
    logic signed [15:0] unit_axis_z;
  } out_item_t;

  // unit axis in q30
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } unit_t;

  // sine and cosine in q30, sign already applied
  typedef struct packed {
    logic signed [32:0] cosv;
    logic signed [32:0] sinv;
    logic               invalid;
  } cs_t;

  // q30 product, floor
  function automatic logic signed [35:0] mulq(input logic signed [33:0] p,
                                              input logic signed [33:0] q);
    logic signed [67:0] pr;
    pr = 68'(p) * 68'(q);
    return pr[65:30];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/axis_angle_rotation_matrix_unit.sv =====
// Rodrigues rotation matrix from an angle and an axis of any length.
// An item is taken in every cycle: busy never rises. Each item comes out on
// result with done high for one cycle, after the axis normalizer (whose square
// root and divide retire one bit per stage) and four stages of products and
// rounding. The sine and cosine cordic runs in parallel behind a matching
// angle delay. The receiver cannot stall, so results must be taken as they
// appear.
// depends on aarm_pkg, aarm_norm, aarm_cordic and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_rotation_matrix_unit_assert.svh"
module axis_angle_rotation_matrix_unit #(
  parameter int COEF_WIDTH = aarm_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire aarm_pkg::in_item_t   cmd,
  output logic                      done,
  output aarm_pkg::out_item_t       result
);

  localparam int DLY = aarm_pkg::ANGLE_DLY;
  localparam int SH  = 32 - COEF_WIDTH;
  localparam logic signed [37:0] RND = 38'((64'(1) << SH) >> 1);
  localparam logic signed [37:0] LIM = 38'(64'(1) << (COEF_WIDTH - 2));

  logic take;
  assign busy = 1'b0;
  assign take = start && !busy;

  // angle waits here so the cordic lands next to the unit axis
  logic signed [15:0] dl_ang [0:DLY-1];
  logic               dl_inv [0:DLY-1];
  logic               dl_vld [0:DLY-1];

  always_ff @(posedge clk) begin
    dl_vld[0] <= rst ? 1'b0 : take;
    dl_ang[0] <= cmd.angle;
    dl_inv[0] <= cmd.angle_invalid;
    for (int i = 1; i < DLY; i++) begin
      dl_vld[i] <= rst ? 1'b0 : dl_vld[i-1];
      dl_ang[i] <= dl_ang[i-1];
      dl_inv[i] <= dl_inv[i-1];
    end
  end

  logic            u_vld;
  aarm_pkg::unit_t unit;
  logic            cs_vld;
  aarm_pkg::cs_t   cs;

  aarm_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .vld_in (take),
    .axis_x (cmd.axis_x),
    .axis_y (cmd.axis_y),
    .axis_z (cmd.axis_z),
    .vld    (u_vld),
    .unit   (unit)
  );

  aarm_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (dl_vld[DLY-1]),
    .angle   (dl_ang[DLY-1]),
    .invalid (dl_inv[DLY-1]),
    .vld     (cs_vld),
    .cs      (cs)
  );

  // stage 0: f = 1 - cos
  logic                m0_vld;
  logic signed [33:0]  m0_f;
  aarm_pkg::cs_t       m0_cs;
  aarm_pkg::unit_t     m0_u;

  always_ff @(posedge clk) begin
    m0_vld <= rst ? 1'b0 : u_vld;
    m0_f   <= aarm_pkg::ONE_Q30 - 34'(cs.cosv);
    m0_cs  <= cs;
    m0_u   <= unit;
  end

  // stage 1: f*u and u*sin
  logic                m1_vld;
  logic signed [35:0]  m1_fx, m1_fy, m1_fz, m1_sx, m1_sy, m1_sz;
  aarm_pkg::cs_t       m1_cs;
  aarm_pkg::unit_t     m1_u;

  always_ff @(posedge clk) begin
    m1_vld <= rst ? 1'b0 : m0_vld;
    m1_fx  <= aarm_pkg::mulq(m0_f, 34'(m0_u.x));
    m1_fy  <= aarm_pkg::mulq(m0_f, 34'(m0_u.y));
    m1_fz  <= aarm_pkg::mulq(m0_f, 34'(m0_u.z));
    m1_sx  <= aarm_pkg::mulq(34'(m0_u.x), 34'(m0_cs.sinv));
    m1_sy  <= aarm_pkg::mulq(34'(m0_u.y), 34'(m0_cs.sinv));
    m1_sz  <= aarm_pkg::mulq(34'(m0_u.z), 34'(m0_cs.sinv));
    m1_cs  <= m0_cs;
    m1_u   <= m0_u;
  end

  // stage 2: outer product terms
  logic                m2_vld;
  logic signed [35:0]  p00, p01, p02, p11, p12, p20, p21, p22;
  logic signed [35:0]  m2_sx, m2_sy, m2_sz;
  aarm_pkg::cs_t       m2_cs;
  aarm_pkg::unit_t     m2_u;

  always_ff @(posedge clk) begin
    m2_vld <= rst ? 1'b0 : m1_vld;
    p00    <= aarm_pkg::mulq(m1_fx[33:0], 34'(m1_u.x));
    p01    <= aarm_pkg::mulq(m1_fx[33:0], 34'(m1_u.y));
    p02    <= aarm_pkg::mulq(m1_fx[33:0], 34'(m1_u.z));
    p11    <= aarm_pkg::mulq(m1_fy[33:0], 34'(m1_u.y));
    p12    <= aarm_pkg::mulq(m1_fy[33:0], 34'(m1_u.z));
    p20    <= aarm_pkg::mulq(m1_fz[33:0], 34'(m1_u.x));
    p21    <= aarm_pkg::mulq(m1_fz[33:0], 34'(m1_u.y));
    p22    <= aarm_pkg::mulq(m1_fz[33:0], 34'(m1_u.z));
    m2_sx  <= m1_sx;
    m2_sy  <= m1_sy;
    m2_sz  <= m1_sz;
    m2_cs  <= m1_cs;
    m2_u   <= m1_u;
  end

  // q30 to output format: round half up, saturate, keep the field bits
  function automatic logic [15:0] to_out(input logic signed [36:0] v);
    logic signed [37:0] r;
    r = (38'(v) + RND) >>> SH;
    if (r > LIM) begin
      r = LIM;
    end
    if (r < -LIM) begin
      r = -LIM;
    end
    return r[15:0];
  endfunction

  logic signed [36:0] m [0:8];
  logic signed [36:0] c37;

  assign c37 = 37'(m2_cs.cosv);

  always_comb begin
    if (m2_cs.invalid) begin
      for (int i = 0; i < 9; i++) begin
        m[i] = '0;
      end
      m[0] = 37'(aarm_pkg::ONE_Q30);
      m[4] = 37'(aarm_pkg::ONE_Q30);
      m[8] = 37'(aarm_pkg::ONE_Q30);
    end else begin
      m[0] = 37'(p00) + c37;
      m[1] = 37'(p01) - 37'(m2_sz);
      m[2] = 37'(p02) + 37'(m2_sy);
      m[3] = 37'(p01) + 37'(m2_sz);
      m[4] = 37'(p11) + c37;
      m[5] = 37'(p12) - 37'(m2_sx);
      m[6] = 37'(p20) - 37'(m2_sy);
      m[7] = 37'(p21) + 37'(m2_sx);
      m[8] = 37'(p22) + c37;
    end
  end

  // stage 3: output register
  logic inv_q;

  always_ff @(posedge clk) begin
    done               <= rst ? 1'b0 : m2_vld;
    inv_q              <= m2_cs.invalid;
    result.r00         <= to_out(m[0]);
    result.r01         <= to_out(m[1]);
    result.r02         <= to_out(m[2]);
    result.r10         <= to_out(m[3]);
    result.r11         <= to_out(m[4]);
    result.r12         <= to_out(m[5]);
    result.r20         <= to_out(m[6]);
    result.r21         <= to_out(m[7]);
    result.r22         <= to_out(m[8]);
    result.unit_axis_x <= to_out(37'(m2_u.x));
    result.unit_axis_y <= to_out(37'(m2_u.y));
    result.unit_axis_z <= to_out(37'(m2_u.z));
  end

  logic unit_in_range;
  logic off_diag_zero;

  assign unit_in_range = unit.x <= aarm_pkg::ONE_Q30 && unit.x >= -aarm_pkg::ONE_Q30
                      && unit.y <= aarm_pkg::ONE_Q30 && unit.y >= -aarm_pkg::ONE_Q30
                      && unit.z <= aarm_pkg::ONE_Q30 && unit.z >= -aarm_pkg::ONE_Q30;
  assign off_diag_zero = result.r01 == '0 && result.r02 == '0 && result.r10 == '0
                      && result.r12 == '0 && result.r20 == '0 && result.r21 == '0;

  `AARM_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `AARM_ASSERT(a_paths_aligned, (u_vld == cs_vld), "norm and cordic paths out of step")
  `AARM_ASSERT(a_unit_bounded, u_vld |-> unit_in_range, "unit axis component beyond one")
  `AARM_ASSERT(a_invalid_identity, (done && inv_q) |-> off_diag_zero, "invalid angle item not identity")

endmodule
`default_nettype wire

// ===== hw/rtl/aarm_norm.sv =====
// axis normalizer: squares, bit-per-stage square root, bit-per-stage divide
// depends on aarm_pkg
`timescale 1ns / 1ps
`default_nettype none
module aarm_norm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               vld_in,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z,
  output logic                    vld,
  output aarm_pkg::unit_t         unit
);

  localparam int NS = aarm_pkg::SQRT_STEPS;
  localparam int ND = aarm_pkg::DIV_STEPS;

  logic [15:0] sq_mag  [0:NS][0:2];
  logic [2:0]  sq_neg  [0:NS];
  logic [31:0] sq_ss   [0:NS];
  logic [33:0] sq_rem  [0:NS];
  logic [31:0] sq_root [0:NS];
  logic        sq_vld  [0:NS];

  logic [32:0] dv_rem  [1:ND][0:2];
  logic [30:0] dv_q    [1:ND][0:2];
  logic [31:0] dv_root [1:ND];
  logic [2:0]  dv_neg  [1:ND];
  logic        dv_vld  [1:ND];

  logic signed [15:0] ax [0:2];
  logic [15:0]        mag_c [0:2];
  logic [31:0]        ss_c;

  assign ax[0] = axis_x;
  assign ax[1] = axis_y;
  assign ax[2] = axis_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = ax[k][15] ? 16'(-ax[k]) : 16'(ax[k]);
    end
    ss_c = 32'(mag_c[0] * mag_c[0]) + 32'(mag_c[1] * mag_c[1]) + 32'(mag_c[2] * mag_c[2]);
  end

  always_ff @(posedge clk) begin
    sq_vld[0] <= rst ? 1'b0 : vld_in;
    for (int k = 0; k < 3; k++) begin
      sq_mag[0][k] <= mag_c[k];
    end
    sq_neg[0]  <= {ax[2][15], ax[1][15], ax[0][15]};
    sq_ss[0]   <= ss_c;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  // root of ss * 2^32, two radicand bits per stage
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam int K = NS - 1 - j;
    logic [1:0]  pair;
    logic [35:0] r4;
    logic [35:0] trial;
    logic        ge;
    if (K >= 16) begin : g_hi
      assign pair = sq_ss[j][2*K-31:2*K-32];
    end else begin : g_lo
      assign pair = 2'b00;
    end
    assign r4    = {sq_rem[j], pair};
    assign trial = {2'b00, sq_root[j], 2'b01};
    assign ge    = (r4 >= trial);
    always_ff @(posedge clk) begin
      sq_vld[j+1]  <= rst ? 1'b0 : sq_vld[j];
      sq_mag[j+1]  <= sq_mag[j];
      sq_neg[j+1]  <= sq_neg[j];
      sq_ss[j+1]   <= sq_ss[j];
      sq_rem[j+1]  <= ge ? 34'(r4 - trial) : 34'(r4);
      sq_root[j+1] <= {sq_root[j][30:0], ge};
    end
  end

  // |a| * 2^46 / root, one quotient bit per stage
  for (genvar d = 0; d < ND; d++) begin : g_div
    logic [32:0] src_rem [0:2];
    logic [30:0] src_q   [0:2];
    logic [31:0] src_root;
    logic [2:0]  src_neg;
    logic        src_vld;
    logic [33:0] r2 [0:2];
    logic [2:0]  ge;
    if (d == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign src_rem[k] = {2'b00, sq_mag[NS][k], 15'b0};
        assign src_q[k]   = '0;
      end
      assign src_root = sq_root[NS];
      assign src_neg  = sq_neg[NS];
      assign src_vld  = sq_vld[NS];
    end else begin : g_rest
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign src_rem[k] = dv_rem[d][k];
        assign src_q[k]   = dv_q[d][k];
      end
      assign src_root = dv_root[d];
      assign src_neg  = dv_neg[d];
      assign src_vld  = dv_vld[d];
    end
    for (genvar k = 0; k < 3; k++) begin : g_step
      assign r2[k] = {src_rem[k], 1'b0};
      assign ge[k] = (r2[k] >= {2'b00, src_root});
    end
    always_ff @(posedge clk) begin
      dv_vld[d+1]  <= rst ? 1'b0 : src_vld;
      dv_root[d+1] <= src_root;
      dv_neg[d+1]  <= src_neg;
      for (int k = 0; k < 3; k++) begin
        dv_rem[d+1][k] <= ge[k] ? 33'(r2[k] - {2'b00, src_root}) : 33'(r2[k]);
        dv_q[d+1][k]   <= {src_q[k][29:0], ge[k]};
      end
    end
  end

  logic signed [31:0] u_c [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [30:0] qc;
      qc = (dv_q[ND][k] > 31'(aarm_pkg::ONE_Q30)) ? 31'(aarm_pkg::ONE_Q30) : dv_q[ND][k];
      if (dv_root[ND] == '0) begin
        u_c[k] = '0;
      end else if (dv_neg[ND][k]) begin
        u_c[k] = -$signed({1'b0, qc});
      end else begin
        u_c[k] = $signed({1'b0, qc});
      end
    end
  end

  always_ff @(posedge clk) begin
    vld    <= rst ? 1'b0 : dv_vld[ND];
    unit.x <= u_c[0];
    unit.y <= u_c[1];
    unit.z <= u_c[2];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aarm_cordic.sv =====
// sine and cosine of a q2.13 angle: range fold by pi, then rotation-mode cordic
// depends on aarm_pkg
`timescale 1ns / 1ps
`default_nettype none
module aarm_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               vld_in,
  input  wire logic signed [15:0] angle,
  input  wire logic               invalid,
  output logic                    vld,
  output aarm_pkg::cs_t           cs
);

  localparam int N = aarm_pkg::CORDIC_STEPS;

  logic signed [32:0] cx   [0:N];
  logic signed [32:0] cy   [0:N];
  logic signed [19:0] cz   [0:N];
  logic               flip [0:N];
  logic               inv  [0:N];
  logic               cvld [0:N];

  logic signed [16:0] ang17;
  logic signed [16:0] red;
  logic               fl;

  assign ang17 = 17'(angle);

  always_comb begin
    red = ang17;
    fl  = 1'b0;
    if (ang17 > aarm_pkg::HALF_PI_Q13) begin
      red = ang17 - aarm_pkg::PI_Q13;
      fl  = 1'b1;
    end else if (ang17 < -aarm_pkg::HALF_PI_Q13) begin
      red = ang17 + aarm_pkg::PI_Q13;
      fl  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cvld[0] <= rst ? 1'b0 : vld_in;
    cx[0]   <= aarm_pkg::CORDIC_GAIN;
    cy[0]   <= '0;
    cz[0]   <= {red, 3'b000};
    flip[0] <= fl;
    inv[0]  <= invalid;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    assign dx = cx[i] >>> i;
    assign dy = cy[i] >>> i;
    always_ff @(posedge clk) begin
      cvld[i+1] <= rst ? 1'b0 : cvld[i];
      flip[i+1] <= flip[i];
      inv[i+1]  <= inv[i];
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - dy;
        cy[i+1] <= cy[i] + dx;
        cz[i+1] <= cz[i] - aarm_pkg::ATAN_TAB[i];
      end else begin
        cx[i+1] <= cx[i] + dy;
        cy[i+1] <= cy[i] - dx;
        cz[i+1] <= cz[i] + aarm_pkg::ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    vld        <= rst ? 1'b0 : cvld[N];
    cs.cosv    <= flip[N] ? -cx[N] : cx[N];
    cs.sinv    <= flip[N] ? -cy[N] : cy[N];
    cs.invalid <= inv[N];
  end

endmodule
`default_nettype wire
